// File: rtl/core/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types, constants and codes of the segment range splitter.
// ----------------------------------------------------------------------------
package srs_pkg;

   localparam int MAX_SEGMENTS = 16;
   localparam int SEG_RUN_CAP  = 16;

   localparam int POS_W  = 48;
   localparam int LEN_W  = 31;
   localparam int CLIP_W = 4;
   localparam int OP_W   = 2;
   localparam int ERR_W  = 2;

   localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam int RUN_W = $clog2(SEG_RUN_CAP + 1);

   localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_MERGE  = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
   localparam logic [ERR_W-1:0] ERR_FULL     = 2'd1;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [POS_W-1:0] push_length;
      logic [POS_W-1:0] request_start;
      logic [LEN_W-1:0] request_length;
   } req_type;

   typedef struct packed {
      logic [CLIP_W-1:0] run_clip;
      logic [POS_W-1:0]  run_start;
      logic [LEN_W-1:0]  run_length;
      logic              run_blank;
      logic [POS_W-1:0]  push_total;
      logic [ERR_W-1:0]  push_error;
      logic              last_item;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic idx_inc;
      logic calc_take;
      logic emit_push;
      logic emit_run;
      logic emit_blank;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic            end_gt_start;
      logic            idx_lt_cnt;
      logic            run_go;
      logic            out_free;
   } status_type;

endpackage

// File: rtl/core/segment_range_splitter_top.sv
// ----------------------------------------------------------------------------
// segment_range_splitter_top
// Cumulative segment boundary table with range split into per-segment runs.
// ----------------------------------------------------------------------------
// One word is taken at a time, in the idle cycle that follows the previous
// word. A push passes a table read state, then a calculation state that
// registers its result. A read passes an address and a compare state for each
// boundary up to the first end above the start, then calc and emit states for
// each segment run (at most 16), with a fetch state before each further run,
// and ends by registering the blank run; with no end above the start it goes
// from the scan straight to the blank run. Each step reads the single
// registered port of the boundary table once, and a stall of a held result
// word while another is ready holds the block in its emitting state. Opcode 3
// is accepted and dropped. The table needs no clearing after reset.
module segment_range_splitter_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  srs_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output srs_pkg::rsp_type rsp_word
);
   import srs_pkg::*;

   cmd_type    cmd;
   status_type status;

   srs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   srs_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// File: rtl/core/srs_ram.sv
// ----------------------------------------------------------------------------
// srs_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module srs_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/srs_ctrl.sv
// ----------------------------------------------------------------------------
// srs_ctrl
// Sequencer for push and read words: steps the datapath through table
// lookups, boundary scan, run emission and the closing blank run.
// ----------------------------------------------------------------------------
module srs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  srs_pkg::status_type status,
   output srs_pkg::cmd_type    cmd
);
   import srs_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_PUSH_RD   = 9'b000000010,
      ST_PUSH_CALC = 9'b000000100,
      ST_SCAN_ADDR = 9'b000001000,
      ST_SCAN_CMP  = 9'b000010000,
      ST_RUN_FETCH = 9'b000100000,
      ST_RUN_CALC  = 9'b001000000,
      ST_RUN_EMIT  = 9'b010000000,
      ST_BLANK     = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.opcode == OP_APPEND || status.opcode == OP_MERGE) begin
                  state_in = ST_PUSH_RD;
               end else if (status.opcode == OP_READ) begin
                  state_in = ST_SCAN_ADDR;
               end
            end
         end
         ST_PUSH_RD: begin
            state_in = ST_PUSH_CALC;
         end
         ST_PUSH_CALC: begin
            if (status.out_free) begin
               cmd.emit_push = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_SCAN_ADDR: begin
            state_in = status.idx_lt_cnt ? ST_SCAN_CMP : ST_BLANK;
         end
         ST_SCAN_CMP: begin
            if (!status.end_gt_start) begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_SCAN_ADDR;
            end else begin
               state_in = status.run_go ? ST_RUN_CALC : ST_BLANK;
            end
         end
         ST_RUN_FETCH: begin
            state_in = status.run_go ? ST_RUN_CALC : ST_BLANK;
         end
         ST_RUN_CALC: begin
            cmd.calc_take = 1'b1;
            state_in      = ST_RUN_EMIT;
         end
         ST_RUN_EMIT: begin
            if (status.out_free) begin
               cmd.emit_run = 1'b1;
               cmd.idx_inc  = 1'b1;
               state_in     = ST_RUN_FETCH;
            end
         end
         ST_BLANK: begin
            if (status.out_free) begin
               cmd.emit_blank = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// File: rtl/core/srs_dpath.sv
// ----------------------------------------------------------------------------
// srs_dpath
// Boundary table, push arithmetic, run cursor and the result register.
// ----------------------------------------------------------------------------
module srs_dpath (
   input  logic                clock,
   input  logic                reset,
   input  srs_pkg::req_type    req_word,
   input  srs_pkg::cmd_type    cmd,
   output srs_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output srs_pkg::rsp_type    rsp_word
);
   import srs_pkg::*;

   logic [OP_W-1:0]  op_ff;
   logic [POS_W-1:0] len_ff;
   logic [POS_W-1:0] start_ff,  start_in;
   logic [LEN_W-1:0] remain_ff, remain_in;
   logic [LEN_W-1:0] take_ff,   take_in;
   logic [CNT_W-1:0] idx_ff,    idx_in;
   logic [RUN_W-1:0] runs_ff,   runs_in;
   logic [CNT_W-1:0] seg_cnt_ff, seg_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_word_ff,  rsp_word_in;

   logic [POS_W-1:0] rd_data;
   logic [POS_W-1:0] base;
   logic [POS_W:0]   sum_wide;
   logic [POS_W-1:0] total;
   logic [POS_W-1:0] avail;
   logic [ERR_W-1:0] err;
   logic             merge_eff;
   logic             table_full;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic             out_free;

   srs_ram #(
      .WIDTH (POS_W),
      .DEPTH (MAX_SEGMENTS)
   ) u_ends (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (total),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // push: base is the last end, or zero for an empty table
   assign merge_eff  = (op_ff == OP_MERGE) && (seg_cnt_ff != '0);
   assign table_full = !merge_eff && (seg_cnt_ff == CNT_W'(MAX_SEGMENTS));
   assign base       = (seg_cnt_ff == '0) ? '0 : rd_data;
   assign sum_wide   = {1'b0, base} + {1'b0, len_ff};

   always_comb begin
      if (table_full) begin
         total = base;
         err   = ERR_FULL;
      end else if (sum_wide[POS_W]) begin
         total = '1;
         err   = ERR_OVERFLOW;
      end else begin
         total = sum_wide[POS_W-1:0];
         err   = ERR_OK;
      end
   end

   assign wr_en   = cmd.emit_push && !table_full;
   assign wr_addr = merge_eff ? idx_ff[IDX_W-1:0] : seg_cnt_ff[IDX_W-1:0];

   // read: run length is min(remaining, end - start)
   assign avail   = rd_data - start_ff;
   assign take_in = (avail < {{(POS_W-LEN_W){1'b0}}, remain_ff}) ?
                    avail[LEN_W-1:0] : remain_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      start_in     = start_ff;
      remain_in    = remain_ff;
      idx_in       = idx_ff;
      runs_in      = runs_ff;
      seg_cnt_in   = seg_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;

      if (cmd.load) begin
         start_in  = req_word.request_start;
         remain_in = req_word.request_length;
         runs_in   = '0;
         if (req_word.opcode == OP_READ || seg_cnt_ff == '0) begin
            idx_in = '0;
         end else begin
            idx_in = seg_cnt_ff - CNT_W'(1);
         end
      end

      if (cmd.idx_inc) begin
         idx_in = idx_ff + CNT_W'(1);
      end

      if (cmd.emit_push) begin
         if (wr_en && !merge_eff) begin
            seg_cnt_in = seg_cnt_ff + CNT_W'(1);
         end
         rsp_valid_in           = 1'b1;
         rsp_word_in            = '0;
         rsp_word_in.push_total = total;
         rsp_word_in.push_error = err;
         rsp_word_in.last_item  = 1'b1;
      end

      if (cmd.emit_run) begin
         remain_in              = remain_ff - take_ff;
         start_in               = start_ff + {{(POS_W-LEN_W){1'b0}}, take_ff};
         runs_in                = runs_ff + RUN_W'(1);
         rsp_valid_in           = 1'b1;
         rsp_word_in            = '0;
         rsp_word_in.run_clip   = CLIP_W'(idx_ff);
         rsp_word_in.run_start  = start_ff;
         rsp_word_in.run_length = take_ff;
      end

      if (cmd.emit_blank) begin
         rsp_valid_in           = 1'b1;
         rsp_word_in            = '0;
         rsp_word_in.run_start  = start_ff;
         rsp_word_in.run_length = remain_ff;
         rsp_word_in.run_blank  = 1'b1;
         rsp_word_in.last_item  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         runs_ff      <= '0;
      end else begin
         seg_cnt_ff   <= seg_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         runs_ff      <= runs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_word.opcode;
         len_ff <= req_word.push_length;
      end
      if (cmd.calc_take) begin
         take_ff <= take_in;
      end
      start_ff    <= start_in;
      remain_ff   <= remain_in;
      idx_ff      <= idx_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign status.opcode       = req_word.opcode;
   assign status.end_gt_start = rd_data > start_ff;
   assign status.idx_lt_cnt   = idx_ff < seg_cnt_ff;
   assign status.run_go       = (remain_ff != '0) && (idx_ff < seg_cnt_ff) &&
                                (runs_ff != RUN_W'(SEG_RUN_CAP));
   assign status.out_free     = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      seg_cnt_ff <= CNT_W'(MAX_SEGMENTS))
      else $error("segment count above table size");

   a_run_cap: assert property (@(posedge clock) disable iff (reset)
      runs_ff <= RUN_W'(SEG_RUN_CAP))
      else $error("run count above cap");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_push || cmd.emit_run || cmd.emit_blank) |-> out_free)
      else $error("result emitted over a held word");

   a_take_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_run |-> (take_ff <= remain_ff))
      else $error("run longer than remaining request");

endmodule
